@@ sv/pcd_pkg.sv @@
// ----------------------------------------------------------------------------
// pcd_pkg
// Shared types and constants of the PCI config and BAR decoder.
// ----------------------------------------------------------------------------
package pcd_pkg;

  // Default sizing
  localparam int MAX_DEVICES_DEF = 8;
  localparam int CFG_BYTES_DEF   = 256;
  localparam int BAR_COUNT_DEF   = 6;

  // Mechanism 1 ports and config space layout
  localparam logic [15:0] LATCH_PORT   = 16'hCF8;
  localparam logic [15:0] DATA_PORT    = 16'hCFC;
  localparam int          ENABLE_BIT   = 31;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] BASE_MASK    = 32'hFFFF_FFF0;
  localparam logic [7:0]  BAR0_OFF     = 8'h10;
  localparam logic [7:0]  CMD_OFF      = 8'h04;
  localparam logic [7:0]  INT_LINE_OFF = 8'h3C;
  localparam logic [7:0]  INT_PIN_OFF  = 8'h3D;
  localparam int          CMD_MEM_BIT  = 1;

  // Configuration registers
  localparam int          CFG_IDX_W       = 4;
  localparam int          CFG_DATA_W      = 48;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 4'd1;
  localparam logic [47:0] WINDOW_BASE_RST = 48'h0000_E000_0000;
  localparam logic [32:0] WINDOW_SIZE_RST = 33'h0_1000_0000;

  // BAR table entry: base, log2 size, type bits
  localparam int BAR_ENTRY_W = 55;

  typedef enum logic [2:0] {
    OP_PORT_OUT  = 3'd0,
    OP_PORT_IN   = 3'd1,
    OP_MMIO_RD   = 3'd2,
    OP_MMIO_WR   = 3'd3,
    OP_REG_DEV   = 3'd4,
    OP_REG_BAR   = 3'd5,
    OP_LOAD_BYTE = 3'd6,
    OP_NONE      = 3'd7
  } opcode_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NO_DEV = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] port;
    logic [2:0]  access_size;
    logic [31:0] data;
    logic [47:0] phys_addr;
    logic [2:0]  bar_number;
    logic [4:0]  bar_size_log2;
    logic        bar_wide;
    logic        bar_prefetchable;
    logic [7:0]  irq_number;
    logic [7:0]  cfg_offset;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        claimed;
    logic        mmio_hit;
    logic [2:0]  hit_device;
    logic [2:0]  hit_bar;
    logic [30:0] hit_offset;
    logic        cfg_write_event;
    logic [1:0]  status;
  } res_t;

endpackage

@@ sv/pcd_if.sv @@
// ----------------------------------------------------------------------------
// pcd_if
// Valid/ready channels of the decoder: request, result and configuration.
// ----------------------------------------------------------------------------
interface pcd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] port;
  logic [2:0]  access_size;
  logic [31:0] data;
  logic [47:0] phys_addr;
  logic [2:0]  bar_number;
  logic [4:0]  bar_size_log2;
  logic        bar_wide;
  logic        bar_prefetchable;
  logic [7:0]  irq_number;
  logic [7:0]  cfg_offset;

  modport source (output valid, opcode, port, access_size, data, phys_addr, bar_number,
                  bar_size_log2, bar_wide, bar_prefetchable, irq_number, cfg_offset,
                  input ready);
  modport sink (input valid, opcode, port, access_size, data, phys_addr, bar_number,
                bar_size_log2, bar_wide, bar_prefetchable, irq_number, cfg_offset,
                output ready);
endinterface

interface pcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        claimed;
  logic        mmio_hit;
  logic [2:0]  hit_device;
  logic [2:0]  hit_bar;
  logic [30:0] hit_offset;
  logic        cfg_write_event;
  logic [1:0]  status;

  modport source (output valid, read_data, claimed, mmio_hit, hit_device, hit_bar,
                  hit_offset, cfg_write_event, status, input ready);
  modport sink (input valid, read_data, claimed, mmio_hit, hit_device, hit_bar,
                hit_offset, cfg_write_event, status, output ready);
endinterface

interface pcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/pcd_ram.sv @@
// ----------------------------------------------------------------------------
// pcd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcd_ram #(
  parameter  int DW    = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pci_config_and_bar_decoder.sv @@
// ----------------------------------------------------------------------------
// pci_config_and_bar_decoder
// Bus 0 host bridge: mechanism 1 config access, device/BAR registration and
// MMIO decode over a byte-wide config RAM and a BAR table RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps both RAMs to zero, one config byte per cycle,
// over all MAX_DEVICES*CFG_BYTES config bytes (2048 by default); no request
// is taken during the sweep, config writes are. One request is in flight at a
// time, and all config space traffic goes through the byte-wide config RAM,
// whose read port is registered. Config reads and writes move one byte at a
// time. An MMIO decode visits the registered devices in order, reading the
// command register of each and then the BARs of each device with memory
// decode on. A finished result sits in an output register, so the next
// request is taken while it waits.
module pci_config_and_bar_decoder #(
  parameter int MAX_DEVICES = pcd_pkg::MAX_DEVICES_DEF,
  parameter int CFG_BYTES   = pcd_pkg::CFG_BYTES_DEF,
  parameter int BAR_COUNT   = pcd_pkg::BAR_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  pcd_in_if.sink   in_ch,
  pcd_out_if.source out_ch,
  pcd_cfg_if.sink  cfg_ch
);
  import pcd_pkg::*;

  localparam int DEV_W     = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int TOT_W     = $clog2(MAX_DEVICES + 1);
  localparam int CFG_DEPTH = MAX_DEVICES * CFG_BYTES;
  localparam int CFG_AW    = $clog2(CFG_DEPTH);
  localparam int BAR_DEPTH = MAX_DEVICES * BAR_COUNT;
  localparam int BAR_AW    = (BAR_DEPTH > 1) ? $clog2(BAR_DEPTH) : 1;

  typedef enum logic [12:0] {
    S_CLEAR   = 13'b0_0000_0000_0001,
    S_IDLE    = 13'b0_0000_0000_0010,
    S_DISPATCH= 13'b0_0000_0000_0100,
    S_CR_RD   = 13'b0_0000_0000_1000,
    S_CR_WT   = 13'b0_0000_0001_0000,
    S_BAR_WT  = 13'b0_0000_0010_0000,
    S_PIN_WT  = 13'b0_0000_0100_0000,
    S_BWR     = 13'b0_0000_1000_0000,
    S_MM_CMD  = 13'b0_0001_0000_0000,
    S_MM_CMDW = 13'b0_0010_0000_0000,
    S_MM_BAR  = 13'b0_0100_0000_0000,
    S_MM_BARW = 13'b0_1000_0000_0000,
    S_FINISH  = 13'b1_0000_0000_0000
  } state_t;

  // Control state
  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CFG_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [31:0]        latch_r, latch_nxt;
  logic [47:0]        wbase_r, wbase_nxt;
  logic [32:0]        wsize_r, wsize_nxt;
  logic [47:0]        nfb_r, nfb_nxt;
  logic [TOT_W-1:0]   dev_total_r, dev_total_nxt;

  // Working payload
  in_item_t           op_r, op_nxt;
  res_t               res_r, res_nxt;
  res_t               out_r, out_nxt;
  logic [TOT_W-1:0]   d_r, d_nxt;
  logic [2:0]         b_r, b_nxt;
  logic [CFG_AW-1:0]  wb_addr_r, wb_addr_nxt;
  logic [63:0]        wb_data_r, wb_data_nxt;
  logic [7:0]         wb_en_r, wb_en_nxt;
  logic [2:0]         rd_idx_r, rd_idx_nxt;
  logic [2:0]         rd_cnt_r, rd_cnt_nxt;
  logic [31:0]        acc_r, acc_nxt;

  // RAM ports
  logic                   cfg_we;
  logic [CFG_AW-1:0]      cfg_waddr, cfg_raddr;
  logic [7:0]             cfg_wdata, cfg_rdata;
  logic                   bar_we;
  logic [BAR_AW-1:0]      bar_waddr, bar_raddr;
  logic [BAR_ENTRY_W-1:0] bar_wdata, bar_rdata;

  pcd_ram #(.DW(8), .DEPTH(CFG_DEPTH)) u_cfg_ram (
    .clk(clk), .we(cfg_we), .waddr(cfg_waddr), .wdata(cfg_wdata),
    .raddr(cfg_raddr), .rdata(cfg_rdata)
  );

  pcd_ram #(.DW(BAR_ENTRY_W), .DEPTH(BAR_DEPTH)) u_bar_ram (
    .clk(clk), .we(bar_we), .waddr(bar_waddr), .wdata(bar_wdata),
    .raddr(bar_raddr), .rdata(bar_rdata)
  );

  // Handshakes
  logic in_xfer, cfg_xfer;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;

  // Config target decode from the address latch
  logic [7:0]        c_bus;
  logic [4:0]        c_dev;
  logic [2:0]        c_func;
  logic [7:0]        c_off;
  logic [DEV_W-1:0]  c_dev_idx;
  logic              tgt_ok, size_ok, in_bar_range;
  logic [CFG_AW-1:0] c_addr;
  logic [BAR_AW-1:0] c_bar_k;
  logic [7:0]        size_mask;

  assign c_bus     = latch_r[23:16];
  assign c_dev     = latch_r[15:11];
  assign c_func    = latch_r[10:8];
  assign c_off     = {latch_r[7:2], op_r.port[1:0]};
  assign c_dev_idx = c_dev[DEV_W-1:0];
  assign tgt_ok    = latch_r[ENABLE_BIT] && (c_bus == 8'd0) && (c_func == 3'd0) &&
                     (7'(c_dev) < 7'(dev_total_r));
  assign size_ok   = (op_r.access_size >= 3'd1) && (op_r.access_size <= 3'd4) &&
                     ((9'(c_off) + 9'(op_r.access_size)) <= 9'(CFG_BYTES));
  assign in_bar_range = (c_off >= BAR0_OFF) &&
                        (9'(c_off) < (9'(BAR0_OFF) + 9'(BAR_COUNT * 4)));
  assign c_addr    = CFG_AW'(int'(c_dev_idx) * CFG_BYTES + int'(c_off));
  assign c_bar_k   = BAR_AW'(int'(c_dev_idx) * BAR_COUNT + int'((c_off - BAR0_OFF) >> 2));

  always_comb begin
    case (op_r.access_size)
      3'd1:    size_mask = 8'h01;
      3'd2:    size_mask = 8'h03;
      3'd3:    size_mask = 8'h07;
      default: size_mask = 8'h0F;
    endcase
  end

  // Newest and next device slots
  logic [TOT_W-1:0]  tot_m1;
  logic [DEV_W-1:0]  last_dev, new_dev;
  assign tot_m1   = dev_total_r - TOT_W'(1);
  assign last_dev = tot_m1[DEV_W-1:0];
  assign new_dev  = dev_total_r[DEV_W-1:0];

  // BAR allocation: align the free pointer to the BAR size
  logic [4:0]  lg_c;
  logic [47:0] sz_c, base_c;
  logic [1:0]  type_c;
  logic [31:0] bar_lo_c;
  assign lg_c     = (op_r.bar_size_log2 < 5'd4) ? 5'd4 : op_r.bar_size_log2;
  assign sz_c     = 48'd1 << lg_c;
  assign base_c   = (nfb_r + sz_c - 48'd1) & ~(sz_c - 48'd1);
  assign type_c   = {op_r.bar_prefetchable, op_r.bar_wide};
  assign bar_lo_c = (base_c[31:0] & BASE_MASK) | {28'd0, type_c, 2'b00};

  // BAR table read fields
  logic [47:0] rb_base;
  logic [4:0]  rb_log;
  logic [1:0]  rb_type;
  logic [31:0] rb_tb, probe_val, assigned_val;
  assign rb_base      = bar_rdata[54:7];
  assign rb_log       = bar_rdata[6:2];
  assign rb_type      = bar_rdata[1:0];
  assign rb_tb        = {28'd0, rb_type, 2'b00};
  assign probe_val    = ~((32'd1 << rb_log) - 32'd1) | rb_tb;
  assign assigned_val = (rb_base[31:0] & BASE_MASK) | rb_tb;

  // MMIO window and BAR hit compare
  logic        in_win, bar_hit;
  logic [47:0] hit_delta;
  assign in_win    = (op_r.phys_addr >= wbase_r) &&
                     (49'(op_r.phys_addr) < (49'(wbase_r) + 49'(wsize_r)));
  assign bar_hit   = (rb_log != 5'd0) && (rb_base != 48'd0) &&
                     (op_r.phys_addr >= rb_base) &&
                     (49'(op_r.phys_addr) < (49'(rb_base) + (49'd1 << rb_log)));
  assign hit_delta = op_r.phys_addr - rb_base;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    clr_cnt_nxt   = clr_cnt_r;
    latch_nxt     = latch_r;
    wbase_nxt     = wbase_r;
    wsize_nxt     = wsize_r;
    nfb_nxt       = nfb_r;
    dev_total_nxt = dev_total_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    d_nxt         = d_r;
    b_nxt         = b_r;
    wb_addr_nxt   = wb_addr_r;
    wb_data_nxt   = wb_data_r;
    wb_en_nxt     = wb_en_r;
    rd_idx_nxt    = rd_idx_r;
    rd_cnt_nxt    = rd_cnt_r;
    acc_nxt       = acc_r;
    cfg_we        = 1'b0;
    cfg_waddr     = wb_addr_r;
    cfg_wdata     = wb_data_r[7:0];
    cfg_raddr     = wb_addr_r;
    bar_we        = 1'b0;
    bar_waddr     = c_bar_k;
    bar_wdata     = '0;
    bar_raddr     = c_bar_k;

    case (state_r)
      // Zero sweep of both RAMs after reset
      S_CLEAR: begin
        cfg_we    = 1'b1;
        cfg_waddr = clr_cnt_r;
        cfg_wdata = 8'd0;
        bar_we    = (32'(clr_cnt_r) < BAR_DEPTH);
        bar_waddr = clr_cnt_r[BAR_AW-1:0];
        clr_cnt_nxt = clr_cnt_r + CFG_AW'(1);
        if (clr_cnt_r == CFG_AW'(CFG_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          op_nxt = '{opcode: in_ch.opcode, port: in_ch.port, access_size: in_ch.access_size,
                     data: in_ch.data, phys_addr: in_ch.phys_addr,
                     bar_number: in_ch.bar_number, bar_size_log2: in_ch.bar_size_log2,
                     bar_wide: in_ch.bar_wide, bar_prefetchable: in_ch.bar_prefetchable,
                     irq_number: in_ch.irq_number, cfg_offset: in_ch.cfg_offset};
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_nxt   = '0;
        state_nxt = S_FINISH;
        case (opcode_t'(op_r.opcode))
          OP_PORT_OUT, OP_PORT_IN: begin
            if (op_r.opcode == OP_PORT_IN) begin
              res_nxt.read_data = ALL_ONES;
            end
            if (op_r.port == LATCH_PORT) begin
              res_nxt.claimed = 1'b1;
              if (op_r.opcode == OP_PORT_OUT) begin
                latch_nxt = op_r.data;
              end else begin
                res_nxt.read_data = latch_r;
              end
            end else if (op_r.port[15:2] == DATA_PORT[15:2]) begin
              res_nxt.claimed = 1'b1;
              wb_addr_nxt     = c_addr;
              if (tgt_ok && size_ok) begin
                if (op_r.opcode == OP_PORT_IN) begin
                  rd_idx_nxt = 3'd0;
                  rd_cnt_nxt = op_r.access_size;
                  acc_nxt    = 32'd0;
                  state_nxt  = S_CR_RD;
                end else if (in_bar_range) begin
                  state_nxt = S_BAR_WT;
                end else begin
                  wb_data_nxt = {32'd0, op_r.data};
                  wb_en_nxt   = size_mask;
                  res_nxt.cfg_write_event = 1'b1;
                  state_nxt   = S_BWR;
                end
              end
            end
          end

          OP_MMIO_RD, OP_MMIO_WR: begin
            if (in_win) begin
              res_nxt.claimed = 1'b1;
              d_nxt     = '0;
              state_nxt = S_MM_CMD;
            end else if (op_r.opcode == OP_MMIO_RD) begin
              res_nxt.read_data = ALL_ONES;
            end
          end

          OP_REG_DEV: begin
            if (dev_total_r == TOT_W'(MAX_DEVICES)) begin
              res_nxt.status = ST_FULL;
            end else begin
              res_nxt.hit_device = 3'(new_dev);
              dev_total_nxt = dev_total_r + TOT_W'(1);
              cfg_raddr     = CFG_AW'(int'(new_dev) * CFG_BYTES + int'(INT_PIN_OFF));
              wb_addr_nxt   = CFG_AW'(int'(new_dev) * CFG_BYTES + int'(INT_LINE_OFF));
              wb_data_nxt   = {48'd0, 8'h01, op_r.irq_number};
              state_nxt     = S_PIN_WT;
            end
          end

          OP_REG_BAR: begin
            if (dev_total_r == '0) begin
              res_nxt.status = ST_NO_DEV;
            end else begin
              res_nxt.hit_device = 3'(last_dev);
              if (32'(op_r.bar_number) < BAR_COUNT) begin
                res_nxt.hit_bar = op_r.bar_number;
                bar_we      = 1'b1;
                bar_waddr   = BAR_AW'(int'(last_dev) * BAR_COUNT + int'(op_r.bar_number));
                bar_wdata   = {base_c, lg_c, type_c};
                nfb_nxt     = base_c + sz_c;
                wb_addr_nxt = CFG_AW'(int'(last_dev) * CFG_BYTES + int'(BAR0_OFF) +
                                      int'(op_r.bar_number) * 4);
                wb_data_nxt = {16'd0, base_c[47:32], bar_lo_c};
                wb_en_nxt   = op_r.bar_wide ? 8'hFF : 8'h0F;
                state_nxt   = S_BWR;
              end
            end
          end

          OP_LOAD_BYTE: begin
            if (dev_total_r == '0) begin
              res_nxt.status = ST_NO_DEV;
            end else begin
              res_nxt.hit_device = 3'(last_dev);
              if (9'(op_r.cfg_offset) < 9'(CFG_BYTES)) begin
                wb_addr_nxt = CFG_AW'(int'(last_dev) * CFG_BYTES + int'(op_r.cfg_offset));
                wb_data_nxt = {56'd0, op_r.data[7:0]};
                wb_en_nxt   = 8'h01;
                state_nxt   = S_BWR;
              end
            end
          end

          default: begin
            res_nxt = '0;
          end
        endcase
      end

      // Config read, one byte at a time: address in S_CR_RD, capture in S_CR_WT
      S_CR_RD: begin
        cfg_raddr = wb_addr_r + CFG_AW'(rd_idx_r);
        state_nxt = S_CR_WT;
      end

      S_CR_WT: begin
        acc_nxt    = acc_r | (32'(cfg_rdata) << {rd_idx_r[1:0], 3'b000});
        rd_idx_nxt = rd_idx_r + 3'd1;
        if ((rd_idx_r + 3'd1) == rd_cnt_r) begin
          res_nxt.read_data = acc_nxt;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CR_RD;
        end
      end

      // Config write into the BAR range: probe or restore if assigned, else plain write
      S_BAR_WT: begin
        if (rb_log != 5'd0) begin
          wb_data_nxt = {32'd0, ((op_r.access_size == 3'd4) && (op_r.data == ALL_ONES)) ?
                                probe_val : assigned_val};
          wb_en_nxt   = 8'h0F;
        end else begin
          wb_data_nxt = {32'd0, op_r.data};
          wb_en_nxt   = size_mask;
          res_nxt.cfg_write_event = 1'b1;
        end
        state_nxt = S_BWR;
      end

      // Interrupt pin default and line; pin at +1, line at +0
      S_PIN_WT: begin
        wb_en_nxt = {6'd0, (cfg_rdata == 8'd0), (op_r.irq_number != 8'd0)};
        state_nxt = S_BWR;
      end

      // Byte write engine, one byte per cycle, masked
      S_BWR: begin
        cfg_we      = wb_en_r[0];
        wb_en_nxt   = wb_en_r >> 1;
        wb_data_nxt = wb_data_r >> 8;
        wb_addr_nxt = wb_addr_r + CFG_AW'(1);
        if (wb_en_r[7:1] == 7'd0) begin
          state_nxt = S_FINISH;
        end
      end

      // MMIO scan: command register of each registered device
      S_MM_CMD: begin
        if (d_r >= dev_total_r) begin
          if (op_r.opcode == OP_MMIO_RD) begin
            res_nxt.read_data = ALL_ONES;
          end
          state_nxt = S_FINISH;
        end else begin
          cfg_raddr = CFG_AW'(int'(d_r[DEV_W-1:0]) * CFG_BYTES + int'(CMD_OFF));
          state_nxt = S_MM_CMDW;
        end
      end

      S_MM_CMDW: begin
        if (cfg_rdata[CMD_MEM_BIT]) begin
          b_nxt     = 3'd0;
          state_nxt = S_MM_BAR;
        end else begin
          d_nxt     = d_r + TOT_W'(1);
          state_nxt = S_MM_CMD;
        end
      end

      S_MM_BAR: begin
        bar_raddr = BAR_AW'(int'(d_r[DEV_W-1:0]) * BAR_COUNT + int'(b_r));
        state_nxt = S_MM_BARW;
      end

      S_MM_BARW: begin
        if (bar_hit) begin
          res_nxt.mmio_hit   = 1'b1;
          res_nxt.hit_device = 3'(d_r);
          res_nxt.hit_bar    = b_r;
          res_nxt.hit_offset = hit_delta[30:0];
          state_nxt = S_FINISH;
        end else if (32'(b_r) == BAR_COUNT - 1) begin
          d_nxt     = d_r + TOT_W'(1);
          state_nxt = S_MM_CMD;
        end else begin
          b_nxt     = b_r + 3'd1;
          state_nxt = S_MM_BAR;
        end
      end

      // Hand the result to the output register
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes
    if (cfg_xfer) begin
      if (cfg_ch.index == REG_WINDOW_BASE) begin
        wbase_nxt = cfg_ch.data;
        nfb_nxt   = cfg_ch.data;
      end else if (cfg_ch.index == REG_WINDOW_SIZE) begin
        wsize_nxt = cfg_ch.data[32:0];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
      latch_r     <= 32'd0;
      wbase_r     <= WINDOW_BASE_RST;
      wsize_r     <= WINDOW_SIZE_RST;
      nfb_r       <= WINDOW_BASE_RST;
      dev_total_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      latch_r     <= latch_nxt;
      wbase_r     <= wbase_nxt;
      wsize_r     <= wsize_nxt;
      nfb_r       <= nfb_nxt;
      dev_total_r <= dev_total_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    d_r       <= d_nxt;
    b_r       <= b_nxt;
    wb_addr_r <= wb_addr_nxt;
    wb_data_r <= wb_data_nxt;
    wb_en_r   <= wb_en_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    acc_r     <= acc_nxt;
  end

  // Result channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = out_r.read_data;
  assign out_ch.claimed         = out_r.claimed;
  assign out_ch.mmio_hit        = out_r.mmio_hit;
  assign out_ch.hit_device      = out_r.hit_device;
  assign out_ch.hit_bar         = out_r.hit_bar;
  assign out_ch.hit_offset      = out_r.hit_offset;
  assign out_ch.cfg_write_event = out_r.cfg_write_event;
  assign out_ch.status          = out_r.status;

`ifndef SYNTHESIS
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dev_total_r) <= MAX_DEVICES)
    else $error("device count past table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cfg_we)
    else $error("config RAM written while idle");

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_DISPATCH))
    else $error("accepted request not dispatched");

  a_status_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |-> (!out_r.mmio_hit && !out_r.claimed))
    else $error("error status with hit or claim");
`endif

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PCI config and BAR decoder. A directed table
// covers reset values, error codes and the corner cases of mechanism 1 and
// BAR setup. Shaped random traffic follows: latch and data port accesses,
// device and BAR registration, config byte loads and MMIO decode. It runs
// over several window settings and idle patterns. Every result is checked
// against a bridge model kept inside the bench or against the directed table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcd_pkg::*;

  localparam int NDEV      = MAX_DEVICES_DEF;
  localparam int NCFG      = CFG_BYTES_DEF;
  localparam int NBAR      = BAR_COUNT_DEF;
  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 200;

  typedef struct {
    in_item_t item;
    bit       typed;
    res_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pcd_in_if  in_ch ();
  pcd_out_if out_ch ();
  pcd_cfg_if cfg_ch ();

  pci_config_and_bar_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bridge model state
  logic [47:0] win_base;
  logic [32:0] win_size;
  logic [31:0] addr_latch;
  logic [47:0] alloc_ptr;
  int unsigned dev_count;
  bit          slot_used [NDEV];
  logic [7:0]  cfg_space [NDEV*NCFG];
  logic [47:0] bar_addr [NDEV*NBAR];
  logic [4:0]  bar_lg [NDEV*NBAR];
  logic [1:0]  bar_kind [NDEV*NBAR];

  res_t pending_results [$];
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   mismatches;
  int   items_sent;
  int   results_seen;
  int   hits_seen;
  int   stall_cycles;

  function automatic bit space_ok(int unsigned dv, int unsigned fn, int unsigned bus,
                                  int unsigned off, int unsigned sz);
    if (bus != 0 || dv >= NDEV || fn != 0 || !slot_used[dv]) return 1'b0;
    if (sz < 1 || sz > 4 || off + sz > NCFG) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void store_dword(int unsigned dv, int unsigned off, logic [31:0] v);
    for (int i = 0; i < 4; i++) cfg_space[dv*NCFG + off + i] = v[i*8 +: 8];
  endfunction

  // Config write through the data port; returns 1 when a plain write landed
  function automatic bit space_write(int unsigned dv, int unsigned fn, int unsigned bus,
                                     int unsigned off, int unsigned sz, logic [31:0] v);
    int unsigned k;
    logic [31:0] tb_bits;
    logic [31:0] w;
    if (!space_ok(dv, fn, bus, off, sz)) return 1'b0;
    if (off >= BAR0_OFF && off < BAR0_OFF + NBAR*4) begin
      k = dv*NBAR + (off - BAR0_OFF) / 4;
      if (bar_lg[k] != 0) begin
        tb_bits = {28'd0, bar_kind[k], 2'b00};
        // size probe or restore of the assigned base
        if (sz == 4 && v == ALL_ONES) w = ~((32'd1 << bar_lg[k]) - 32'd1) | tb_bits;
        else w = (bar_addr[k][31:0] & BASE_MASK) | tb_bits;
        store_dword(dv, off, w);
        return 1'b0;
      end
    end
    for (int i = 0; i < sz; i++) cfg_space[dv*NCFG + off + i] = v[i*8 +: 8];
    return 1'b1;
  endfunction

  function automatic logic [31:0] space_read(int unsigned dv, int unsigned fn,
                                             int unsigned bus, int unsigned off,
                                             int unsigned sz);
    logic [31:0] v;
    v = '0;
    if (!space_ok(dv, fn, bus, off, sz)) return ALL_ONES;
    for (int i = 0; i < sz; i++) v[i*8 +: 8] = cfg_space[dv*NCFG + off + i];
    return v;
  endfunction

  // Expected result of one request; updates the model state
  function automatic res_t bridge_predict(in_item_t it);
    res_t r;
    int unsigned bus, dv, fn, off, s, k, lg;
    logic [63:0] sz, base, phys, lim;
    bit found;
    r = '0;
    phys = {16'd0, it.phys_addr};
    case (opcode_t'(it.opcode))
      OP_PORT_OUT, OP_PORT_IN: begin
        if (opcode_t'(it.opcode) == OP_PORT_IN) r.read_data = ALL_ONES;
        if (it.port == LATCH_PORT) begin
          r.claimed = 1'b1;
          if (opcode_t'(it.opcode) == OP_PORT_OUT) addr_latch = it.data;
          else r.read_data = addr_latch;
        end else if (it.port >= DATA_PORT && it.port <= DATA_PORT + 16'd3) begin
          r.claimed = 1'b1;
          if (addr_latch[ENABLE_BIT]) begin
            bus = addr_latch[23:16];
            dv  = addr_latch[15:11];
            fn  = addr_latch[10:8];
            off = {addr_latch[7:2], 2'b00} | (it.port - DATA_PORT);
            if (opcode_t'(it.opcode) == OP_PORT_OUT)
              r.cfg_write_event = space_write(dv, fn, bus, off, it.access_size, it.data);
            else
              r.read_data = space_read(dv, fn, bus, off, it.access_size);
          end
        end
      end
      OP_MMIO_RD, OP_MMIO_WR: begin
        lim = {16'd0, win_base} + {31'd0, win_size};
        if (phys >= {16'd0, win_base} && phys < lim) begin
          r.claimed = 1'b1;
          found = 1'b0;
          for (int d = 0; d < dev_count && d < NDEV && !found; d++) begin
            if (slot_used[d] && cfg_space[d*NCFG + CMD_OFF][CMD_MEM_BIT]) begin
              for (int b = 0; b < NBAR && !found; b++) begin
                k = d*NBAR + b;
                if (bar_lg[k] != 0 && bar_addr[k] != 0 &&
                    phys >= {16'd0, bar_addr[k]} &&
                    phys < {16'd0, bar_addr[k]} + (64'd1 << bar_lg[k])) begin
                  r.mmio_hit   = 1'b1;
                  r.hit_device = d[2:0];
                  r.hit_bar    = b[2:0];
                  base         = phys - {16'd0, bar_addr[k]};
                  r.hit_offset = base[30:0];
                  found = 1'b1;
                end
              end
            end
          end
          if (!found && opcode_t'(it.opcode) == OP_MMIO_RD) r.read_data = ALL_ONES;
        end else if (opcode_t'(it.opcode) == OP_MMIO_RD) begin
          r.read_data = ALL_ONES;
        end
      end
      OP_REG_DEV: begin
        if (dev_count >= NDEV) begin
          r.status = ST_FULL;
        end else begin
          s = dev_count;
          dev_count++;
          slot_used[s] = 1'b1;
          if (cfg_space[s*NCFG + INT_PIN_OFF] == 8'd0) cfg_space[s*NCFG + INT_PIN_OFF] = 8'd1;
          if (it.irq_number != 0) cfg_space[s*NCFG + INT_LINE_OFF] = it.irq_number;
          r.hit_device = s[2:0];
        end
      end
      OP_REG_BAR: begin
        if (dev_count == 0) begin
          r.status = ST_NO_DEV;
        end else begin
          s = dev_count - 1;
          r.hit_device = s[2:0];
          if (it.bar_number < NBAR) begin
            k  = s*NBAR + it.bar_number;
            lg = (it.bar_size_log2 < 4) ? 4 : it.bar_size_log2;
            sz = 64'd1 << lg;
            base = (({16'd0, alloc_ptr} + sz - 64'd1) & ~(sz - 64'd1)) & MASK48;
            alloc_ptr   = base[47:0] + sz[47:0];
            bar_addr[k] = base[47:0];
            bar_lg[k]   = lg[4:0];
            bar_kind[k] = {it.bar_prefetchable, it.bar_wide};
            store_dword(s, BAR0_OFF + it.bar_number*4,
                        (base[31:0] & BASE_MASK) | {28'd0, bar_kind[k], 2'b00});
            if (it.bar_wide)
              store_dword(s, BAR0_OFF + (it.bar_number + 1)*4, {16'd0, base[47:32]});
            r.hit_bar = it.bar_number;
          end
        end
      end
      OP_LOAD_BYTE: begin
        if (dev_count == 0) begin
          r.status = ST_NO_DEV;
        end else begin
          s = dev_count - 1;
          r.hit_device = s[2:0];
          if (it.cfg_offset < NCFG) cfg_space[s*NCFG + it.cfg_offset] = it.data[7:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t blank(opcode_t op);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.access_size = 3'd4;
    return it;
  endfunction

  function automatic in_item_t port_item(opcode_t op, logic [15:0] p, logic [2:0] sz,
                                         logic [31:0] d);
    in_item_t it;
    it = blank(op);
    it.port = p;
    it.access_size = sz;
    it.data = d;
    return it;
  endfunction

  function automatic in_item_t bar_item(logic [2:0] n, logic [4:0] lg, bit wide, bit pref);
    in_item_t it;
    it = blank(OP_REG_BAR);
    it.bar_number = n;
    it.bar_size_log2 = lg;
    it.bar_wide = wide;
    it.bar_prefetchable = pref;
    return it;
  endfunction

  function automatic in_item_t byte_item(logic [7:0] off, logic [7:0] d);
    in_item_t it;
    it = blank(OP_LOAD_BYTE);
    it.cfg_offset = off;
    it.data = {$urandom_range(0, 16'hFFFF), $urandom_range(0, 8'hFF), d};
    return it;
  endfunction

  function automatic res_t res_of(logic [31:0] rd, bit cl, logic [1:0] st);
    res_t r;
    r = '0;
    r.read_data = rd;
    r.claimed = cl;
    r.status = st;
    return r;
  endfunction

  // Latch value aimed mostly at bus 0, function 0 and table device slots, often at the BAR area
  function automatic logic [31:0] latch_value();
    logic [31:0] v;
    v = $urandom;
    v[31] = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 99) < 85) v[23:16] = 8'd0;
    if ($urandom_range(0, 99) < 85) v[15:11] = $urandom_range(0, NDEV - 1);
    if ($urandom_range(0, 99) < 85) v[10:8] = 3'd0;
    if ($urandom_range(0, 1) == 0) v[7:0] = $urandom_range(BAR0_OFF, BAR0_OFF + NBAR*4 - 1);
    else if ($urandom_range(0, 3) == 0) v[7:0] = CMD_OFF;
    return v;
  endfunction

  function automatic logic [47:0] mmio_addr();
    int unsigned cand [$];
    int unsigned k;
    logic [63:0] span, off;
    for (int i = 0; i < NDEV*NBAR; i++) if (bar_lg[i] != 0) cand.push_back(i);
    if (cand.size() != 0 && $urandom_range(0, 99) < 60) begin
      k = cand[$urandom_range(0, cand.size() - 1)];
      span = 64'd1 << bar_lg[k];
      case ($urandom_range(0, 3))
        0: off = 0;
        1: off = span - 1;
        2: off = span;
        default: off = {$urandom, $urandom} % span;
      endcase
      return bar_addr[k] + off[47:0];
    end
    if ($urandom_range(0, 99) < 70)
      return win_base + 48'({$urandom, $urandom} % {31'd0, win_size});
    return rand48();
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise: every field fully random
      it = {$urandom, $urandom, $urandom, $urandom};
    end else if (pick < 18) begin
      it = port_item(OP_PORT_OUT, LATCH_PORT, $urandom_range(0, 7), latch_value());
    end else if (pick < 21) begin
      it = port_item(OP_PORT_IN, ($urandom_range(0, 3) == 0) ? 16'($urandom) : LATCH_PORT,
                     $urandom_range(0, 7), $urandom);
    end else if (pick < 44) begin
      it = port_item(($urandom_range(0, 1) == 0) ? OP_PORT_OUT : OP_PORT_IN,
                     DATA_PORT + $urandom_range(0, 3),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4),
                     ($urandom_range(0, 4) == 0) ? ALL_ONES : $urandom);
    end else if (pick < 70) begin
      it = blank(($urandom_range(0, 1) == 0) ? OP_MMIO_RD : OP_MMIO_WR);
      it.phys_addr = mmio_addr();
      it.data = $urandom;
    end else if (pick < 73) begin
      it = blank(OP_REG_DEV);
      it.irq_number = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom);
    end else if (pick < 84) begin
      it = bar_item(($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 5),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(13, 31) :
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 12),
                    $urandom_range(0, 1), $urandom_range(0, 1));
    end else begin
      case ($urandom_range(0, 3))
        0: it = byte_item(CMD_OFF, ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h02);
        1: it = byte_item($urandom_range(INT_LINE_OFF, INT_PIN_OFF), $urandom);
        2: it = byte_item($urandom_range(BAR0_OFF, BAR0_OFF + NBAR*4 - 1), $urandom);
        default: it = byte_item($urandom, $urandom);
      endcase
    end
    return it;
  endfunction

  // One request transfer; the expectation is queued at acceptance
  task automatic send_request(in_item_t it, bit typed, res_t typed_res);
    res_t p;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= it.opcode;
    in_ch.port             <= it.port;
    in_ch.access_size      <= it.access_size;
    in_ch.data             <= it.data;
    in_ch.phys_addr        <= it.phys_addr;
    in_ch.bar_number       <= it.bar_number;
    in_ch.bar_size_log2    <= it.bar_size_log2;
    in_ch.bar_wide         <= it.bar_wide;
    in_ch.bar_prefetchable <= it.bar_prefetchable;
    in_ch.irq_number       <= it.irq_number;
    in_ch.cfg_offset       <= it.cfg_offset;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = bridge_predict(it);
    pending_results.push_back(typed ? typed_res : p);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write; only issued while no request is outstanding
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [47:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_WINDOW_BASE) begin
      win_base  = v;
      alloc_ptr = v;
    end else if (idx == REG_WINDOW_SIZE) begin
      win_size = v[32:0];
    end
  endtask

  // Result side: check each transfer, then pick next ready
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.read_data, out_ch.claimed, out_ch.mmio_hit, out_ch.hit_device,
              out_ch.hit_bar, out_ch.hit_offset, out_ch.cfg_write_event, out_ch.status};
      results_seen++;
      if (got.mmio_hit) hits_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transfer %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.claimed !== want.claimed ||
            got.mmio_hit !== want.mmio_hit || got.hit_device !== want.hit_device ||
            got.hit_bar !== want.hit_bar || got.hit_offset !== want.hit_offset ||
            got.cfg_write_event !== want.cfg_write_event || got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d mismatch\n  exp %p\n  act %p", results_seen, want, got);
        end
      end
    end
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    stim_row_t   rows [$];
    in_item_t    it;
    res_t        none;
    logic [47:0] bases [4];
    logic [32:0] sizes [4];
    int          counts [4];

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.opcode, in_ch.port, in_ch.access_size, in_ch.data, in_ch.phys_addr} = '0;
    {in_ch.bar_number, in_ch.bar_size_log2, in_ch.bar_wide, in_ch.bar_prefetchable} = '0;
    {in_ch.irq_number, in_ch.cfg_offset} = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    stall_cycles = 0;
    tx_idle_pct = 28;
    rx_idle_pct = 76;

    // model reset
    win_base = WINDOW_BASE_RST;
    win_size = WINDOW_SIZE_RST;
    alloc_ptr = WINDOW_BASE_RST;
    addr_latch = '0;
    dev_count = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    foreach (cfg_space[i]) cfg_space[i] = 8'd0;
    foreach (bar_addr[i]) begin
      bar_addr[i] = '0;
      bar_lg[i] = '0;
      bar_kind[i] = '0;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    none = '0;
    rows.push_back('{port_item(OP_PORT_IN, LATCH_PORT, 4, 0), 1, res_of(32'd0, 1, ST_OK)});
    rows.push_back('{port_item(OP_PORT_IN, 16'h1234, 4, 0), 1, res_of(ALL_ONES, 0, ST_OK)});
    rows.push_back('{port_item(OP_PORT_IN, DATA_PORT, 4, 0), 1, res_of(ALL_ONES, 1, ST_OK)});
    rows.push_back('{bar_item(0, 12, 0, 0), 1, res_of(0, 0, ST_NO_DEV)});
    rows.push_back('{byte_item(CMD_OFF, 8'h02), 1, res_of(0, 0, ST_NO_DEV)});
    it = blank(OP_MMIO_RD);
    rows.push_back('{it, 1, res_of(ALL_ONES, 0, ST_OK)});
    it = '1;
    rows.push_back('{it, 1, none});
    it = blank(OP_REG_DEV);
    rows.push_back('{it, 0, none});
    rows.push_back('{bar_item(0, 0, 1, 1), 0, none});
    rows.push_back('{bar_item(6, 8, 0, 0), 0, none});
    rows.push_back('{bar_item(5, 31, 1, 1), 0, none});
    rows.push_back('{bar_item(2, 4, 0, 1), 0, none});
    rows.push_back('{byte_item(CMD_OFF, 8'h02), 0, none});
    rows.push_back('{byte_item(INT_PIN_OFF, 8'h00), 0, none});
    rows.push_back('{port_item(OP_PORT_OUT, LATCH_PORT, 0, 32'h8000_0010), 0, none});
    rows.push_back('{port_item(OP_PORT_OUT, DATA_PORT, 4, ALL_ONES), 0, none});
    rows.push_back('{port_item(OP_PORT_IN, DATA_PORT, 4, 0), 0, none});
    rows.push_back('{port_item(OP_PORT_OUT, DATA_PORT + 1, 2, 32'h1234_5678), 0, none});
    rows.push_back('{port_item(OP_PORT_IN, DATA_PORT, 0, 0), 1, res_of(ALL_ONES, 1, ST_OK)});
    rows.push_back('{port_item(OP_PORT_OUT, LATCH_PORT, 4, 32'h8000_00FC), 0, none});
    rows.push_back('{port_item(OP_PORT_IN, DATA_PORT + 3, 2, 0), 1,
                     res_of(ALL_ONES, 1, ST_OK)});
    rows.push_back('{port_item(OP_PORT_OUT, DATA_PORT + 2, 1, 32'hFFFF_FFA5), 0, none});
    it = blank(OP_MMIO_RD);
    it.phys_addr = 48'hE000_0000;
    rows.push_back('{it, 0, none});
    it = blank(OP_MMIO_WR);
    it.phys_addr = 48'hEFFF_FFFF;
    rows.push_back('{it, 0, none});
    it = blank(OP_REG_DEV);
    it.irq_number = 8'hFF;
    rows.push_back('{it, 0, none});

    // Phase settings: defaults, top of the address space, minimum size, a 1 GiB window at 2 GiB
    bases  = '{WINDOW_BASE_RST, 48'hFFFF_FFFF_F000, 48'h0, 48'h0000_8000_0000};
    sizes  = '{WINDOW_SIZE_RST, 33'h1_0000_0000, 33'd1, 33'h0_4000_0000};
    counts = '{220, 220, 80, 180};

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(REG_WINDOW_BASE, bases[ph]);
      write_reg(REG_WINDOW_SIZE, {15'd0, sizes[ph]});
      tx_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 76 : 0;
      rx_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 28 : 0;
      if (ph == 0)
        foreach (rows[i]) send_request(rows[i].item, rows[i].typed, rows[i].res);
      for (int i = 0; i < counts[ph]; i++) begin
        if (i % 97 == 50) drain();
        send_request(random_item(), 0, none);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests over 4 window settings, %0d results, %0d BAR hits,",
             items_sent, results_seen, hits_seen);
    $display("%0d devices registered; %0d mismatches.", dev_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ pci_config_and_bar_decoder.f @@
sv/pcd_pkg.sv
sv/pcd_if.sv
sv/pcd_ram.sv
sv/pci_config_and_bar_decoder.sv
test/tb.sv
